// File: design/pfe_pkg.sv
// shared types, constants and square lookup functions of the playfair encryptor
package pfe_pkg;

  localparam int unsigned SIDE            = 5;
  localparam int unsigned LETTER_W        = 5;
  localparam int unsigned ROW_W           = SIDE * LETTER_W;
  localparam int unsigned COORD_W         = 3;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = ROW_W;
  localparam int unsigned PAIR_FIFO_DEPTH = 4;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [SIDE-1:0][ROW_W-1:0] square_t;

  localparam letter_t FILL_MAIN      = 5'd23;
  localparam letter_t FILL_ALT       = 5'd21;
  localparam letter_t ABSENT_RESET   = 5'd9;
  localparam letter_t STAND_IN_RESET = 5'd8;

  // row 4 first: VWXYZ, QRSTU, LMNOP, FGHIK, ABCDE
  localparam square_t SQUARE_RESET = {
    25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_0    = 3'd0,
    CFG_ROW_1    = 3'd1,
    CFG_ROW_2    = 3'd2,
    CFG_ROW_3    = 3'd3,
    CFG_ROW_4    = 3'd4,
    CFG_ABSENT   = 3'd5,
    CFG_STAND_IN = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    letter_t plain_letter;
    logic    end_of_message;
  } in_item_t;

  typedef struct packed {
    letter_t cipher_letter;
    logic    final_letter;
  } out_item_t;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    last;
  } pair_t;

  typedef struct packed {
    logic  push0;
    logic  push1;
    pair_t entry0;
    pair_t entry1;
  } pair_push_t;

  typedef struct packed {
    logic  valid;
    pair_t entry;
  } pair_head_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  function automatic letter_t cell_at(square_t sq, coord_t r, coord_t c);
    logic [ROW_W-1:0] row;
    row = sq[r];
    return row[c*LETTER_W +: LETTER_W];
  endfunction

  function automatic coord_t wrap_inc(coord_t x);
    return (x == coord_t'(SIDE - 1)) ? '0 : x + coord_t'(1);
  endfunction

  function automatic letter_t substitute(letter_t l, letter_t absent, letter_t stand_in);
    return (l == absent) ? stand_in : l;
  endfunction

  function automatic letter_t filler_for(letter_t l, letter_t absent, letter_t stand_in);
    return substitute((l == FILL_MAIN) ? FILL_ALT : FILL_MAIN, absent, stand_in);
  endfunction

  // last match in row-major order wins, no match gives row 0 column 0
  function automatic pos_t locate(square_t sq, letter_t l);
    pos_t pos;
    pos = '0;
    for (int i = 0; i < SIDE; i++) begin
      for (int j = 0; j < SIDE; j++) begin
        if (cell_at(sq, coord_t'(i), coord_t'(j)) == l) begin
          pos.row = coord_t'(i);
          pos.col = coord_t'(j);
        end
      end
    end
    return pos;
  endfunction

endpackage

// File: design/pfe_front.sv
// front end: stand-in rule, digraph splitting and filler insertion
module pfe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  pfe_pkg::in_item_t  item_i,
  input  pfe_pkg::letter_t   absent_i,
  input  pfe_pkg::letter_t   stand_in_i,
  output pfe_pkg::pair_push_t push_o
);

  pfe_pkg::letter_t pending_q, pending_d;
  logic             pend_valid_q, pend_valid_d;

  pfe_pkg::letter_t letter;
  pfe_pkg::letter_t pend_after;
  logic             pend_after_valid;
  logic             has_pair;
  logic             has_tail;
  pfe_pkg::pair_t   pair0;
  pfe_pkg::pair_t   tail;

  always_comb begin
    letter           = pfe_pkg::substitute(item_i.plain_letter, absent_i, stand_in_i);
    pair0            = '0;
    has_pair         = pend_valid_q;
    pend_after       = letter;
    pend_after_valid = 1'b1;
    if (pend_valid_q) begin
      if (letter == pending_q) begin
        // doubled letter: pair the pending one with a filler
        pair0.first  = pending_q;
        pair0.second = pfe_pkg::filler_for(pending_q, absent_i, stand_in_i);
      end else begin
        pair0.first      = pending_q;
        pair0.second     = letter;
        pend_after_valid = 1'b0;
      end
    end
    has_tail    = item_i.end_of_message & pend_after_valid;
    tail.first  = pend_after;
    tail.second = pfe_pkg::filler_for(pend_after, absent_i, stand_in_i);
    tail.last   = 1'b1;
    pair0.last  = item_i.end_of_message & ~has_tail;

    push_o.push0  = accept_i & (has_pair | has_tail);
    push_o.push1  = accept_i & has_pair & has_tail;
    push_o.entry0 = has_pair ? pair0 : tail;
    push_o.entry1 = tail;

    pending_d    = pending_q;
    pend_valid_d = pend_valid_q;
    if (accept_i) begin
      if (item_i.end_of_message) begin
        pending_d    = '0;
        pend_valid_d = 1'b0;
      end else begin
        pending_d    = pend_after_valid ? pend_after : '0;
        pend_valid_d = pend_after_valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      pending_q    <= pending_d;
      pend_valid_q <= pend_valid_d;
    end
  end

endmodule

// File: design/pfe_pair_fifo.sv
// short digraph queue between front and back, takes up to two pairs a cycle
module pfe_pair_fifo #(
  parameter int unsigned Depth = pfe_pkg::PAIR_FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfe_pkg::pair_push_t push_i,
  input  logic                pop_i,
  output pfe_pkg::pair_head_t head_o,
  output logic                full_o
);

  localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CNT_W = $clog2(Depth + 1);

  pfe_pkg::pair_t entries_q [Depth];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] wr_next;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(Depth - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_next = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.push1) begin
      wr_ptr_d = ptr_inc(wr_next);
    end else if (push_i.push0) begin
      wr_ptr_d = wr_next;
    end
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i.push0) + CNT_W'(push_i.push1) - CNT_W'(pop_i);
  end

  // room for two pairs is needed before an item may enter
  assign full_o       = count_q > CNT_W'(Depth - 2);
  assign head_o.valid = count_q != '0;
  assign head_o.entry = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      entries_q[wr_ptr_q] <= push_i.entry0;
    end
    if (push_i.push1) begin
      entries_q[wr_next] <= push_i.entry1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: design/pfe_back.sv
// back end: square lookup, playfair rules and two-letter output sequencing
module pfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfe_pkg::square_t    square_i,
  input  pfe_pkg::pair_head_t head_i,
  output logic                pop_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output pfe_pkg::out_item_t  out_item_o
);

  pfe_pkg::pos_t      pa, pb;
  pfe_pkg::letter_t   enc0, enc1;
  logic               take;
  logic               out_valid_q, out_valid_d;
  logic               hold_valid_q, hold_valid_d;
  pfe_pkg::out_item_t out_q, out_d;
  pfe_pkg::out_item_t hold_q, hold_d;

  always_comb begin
    pa = pfe_pkg::locate(square_i, head_i.entry.first);
    pb = pfe_pkg::locate(square_i, head_i.entry.second);
    if (pa.row == pb.row) begin
      enc0 = pfe_pkg::cell_at(square_i, pa.row, pfe_pkg::wrap_inc(pa.col));
      enc1 = pfe_pkg::cell_at(square_i, pb.row, pfe_pkg::wrap_inc(pb.col));
    end else if (pa.col == pb.col) begin
      enc0 = pfe_pkg::cell_at(square_i, pfe_pkg::wrap_inc(pa.row), pa.col);
      enc1 = pfe_pkg::cell_at(square_i, pfe_pkg::wrap_inc(pb.row), pb.col);
    end else begin
      enc0 = pfe_pkg::cell_at(square_i, pa.row, pb.col);
      enc1 = pfe_pkg::cell_at(square_i, pb.row, pa.col);
    end
  end

  assign take  = out_valid_q & ~out_stall_i;
  assign pop_o = head_i.valid & (~out_valid_q | (take & ~hold_valid_q));

  always_comb begin
    out_valid_d  = out_valid_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    hold_d       = hold_q;
    if (pop_o) begin
      out_valid_d  = 1'b1;
      hold_valid_d = 1'b1;
      out_d        = '{cipher_letter: enc0, final_letter: 1'b0};
      hold_d       = '{cipher_letter: enc1, final_letter: head_i.entry.last};
    end else if (take) begin
      out_valid_d  = hold_valid_q;
      hold_valid_d = 1'b0;
      out_d        = hold_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

endmodule

// File: design/playfair_digraph_encrypt_core.sv
// top level of the streaming playfair digraph encryptor
// throughput: one cipher letter per cycle while out_stall_i is low, set by the back end's
//   output register; items enter every cycle while the pair queue has room for two digraphs
// reset: clears the pending letter, pair queue and output stage, and loads the default
//   square (ABCDE FGHIK LMNOP QRSTU VWXYZ) with j absent and i as stand-in
module playfair_digraph_encrypt_core #(
  parameter int unsigned PairFifoDepth = pfe_pkg::PAIR_FIFO_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // plaintext letters
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pfe_pkg::in_item_t                 in_item_i,
  // ciphertext letters
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pfe_pkg::out_item_t                out_item_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pfe_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // configuration registers
  pfe_pkg::square_t square_q;
  pfe_pkg::letter_t absent_q;
  pfe_pkg::letter_t stand_in_q;

  // front to queue to back
  pfe_pkg::pair_push_t push;
  pfe_pkg::pair_head_t head;
  logic                fifo_full;
  logic                pop;
  logic                in_accept;

  // config writes are always taken, unknown indexes fall through
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_q   <= pfe_pkg::SQUARE_RESET;
      absent_q   <= pfe_pkg::ABSENT_RESET;
      stand_in_q <= pfe_pkg::STAND_IN_RESET;
    end else if (cfg_valid_i) begin
      unique case (pfe_pkg::cfg_idx_e'(cfg_index_i))
        pfe_pkg::CFG_ROW_0:    square_q[0] <= cfg_data_i[pfe_pkg::ROW_W-1:0];
        pfe_pkg::CFG_ROW_1:    square_q[1] <= cfg_data_i[pfe_pkg::ROW_W-1:0];
        pfe_pkg::CFG_ROW_2:    square_q[2] <= cfg_data_i[pfe_pkg::ROW_W-1:0];
        pfe_pkg::CFG_ROW_3:    square_q[3] <= cfg_data_i[pfe_pkg::ROW_W-1:0];
        pfe_pkg::CFG_ROW_4:    square_q[4] <= cfg_data_i[pfe_pkg::ROW_W-1:0];
        pfe_pkg::CFG_ABSENT:   absent_q    <= cfg_data_i[pfe_pkg::LETTER_W-1:0];
        pfe_pkg::CFG_STAND_IN: stand_in_q  <= cfg_data_i[pfe_pkg::LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  // an item may yield two digraphs, so stall unless two queue slots are free
  assign in_stall_o = fifo_full;
  assign in_accept  = in_valid_i & ~fifo_full;

  pfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .item_i     (in_item_i),
    .absent_i   (absent_q),
    .stand_in_i (stand_in_q),
    .push_o     (push)
  );

  pfe_pair_fifo #(
    .Depth (PairFifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (fifo_full)
  );

  // back end pulls one digraph each time its output pair drains
  pfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .square_i    (square_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// File: bench/testbench.sv
// self-checking bench for the playfair digraph encryptor: directed table, then random phases
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int PHASES          = 7;
  localparam int PHASE_ITEMS     = 50;
  localparam int MAX_REPORTS     = 10;

  typedef logic [pfe_pkg::CFG_IDX_W-1:0]  cfg_index_t;
  typedef logic [pfe_pkg::CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [pfe_pkg::ROW_W-1:0]      row_t;

  // index just past the register map, the block must drop writes to it
  localparam cfg_index_t CFG_PAST_END = 3'd7;

  typedef struct {
    bit               is_reg;
    cfg_index_t       reg_index;
    cfg_data_t        reg_value;
    pfe_pkg::letter_t letter;
    bit               eom;
    string            known;  // ciphertext read off the square, empty for predicted rows
  } plan_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  pfe_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  pfe_pkg::out_item_t out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  cfg_index_t         cfg_index_i = '0;
  cfg_data_t          cfg_data_i  = '0;

  // cipher model state
  row_t             square_rows [5];
  pfe_pkg::letter_t absent_code;
  pfe_pkg::letter_t stand_in_code;
  pfe_pkg::letter_t held_letter;
  bit               held_valid;

  pfe_pkg::out_item_t cipher_due [$];    // ciphertext letters still owed by the block
  pfe_pkg::out_item_t step_letters [$];  // ciphertext caused by one plaintext letter

  int failures     = 0;
  int cycles       = 0;
  int burst_left   = 0;
  bit hold_off_due = 1'b0;

  playfair_digraph_encrypt_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- cipher model ----------------

  function automatic pfe_pkg::letter_t square_cell(int r, int c);
    return square_rows[r][c*pfe_pkg::LETTER_W +: pfe_pkg::LETTER_W];
  endfunction

  function automatic pfe_pkg::letter_t plug_gap(pfe_pkg::letter_t l);
    return (l == absent_code) ? stand_in_code : l;
  endfunction

  function automatic pfe_pkg::letter_t pad_for(pfe_pkg::letter_t l);
    return plug_gap((l == pfe_pkg::FILL_MAIN) ? pfe_pkg::FILL_ALT : pfe_pkg::FILL_MAIN);
  endfunction

  // last hit in row-major order wins, a missing letter sits at the top left
  function automatic void find_cell(pfe_pkg::letter_t l, output int r, output int c);
    r = 0;
    c = 0;
    for (int i = 0; i < pfe_pkg::SIDE; i++) begin
      for (int j = 0; j < pfe_pkg::SIDE; j++) begin
        if (square_cell(i, j) == l) begin
          r = i;
          c = j;
        end
      end
    end
  endfunction

  function automatic void encipher(pfe_pkg::letter_t a, pfe_pkg::letter_t b);
    int ra, ca, rb, cb;
    find_cell(a, ra, ca);
    find_cell(b, rb, cb);
    if (ra == rb) begin
      step_letters.push_back(
        pfe_pkg::out_item_t'{square_cell(ra, (ca + 1) % pfe_pkg::SIDE), 1'b0});
      step_letters.push_back(
        pfe_pkg::out_item_t'{square_cell(rb, (cb + 1) % pfe_pkg::SIDE), 1'b0});
    end else if (ca == cb) begin
      step_letters.push_back(
        pfe_pkg::out_item_t'{square_cell((ra + 1) % pfe_pkg::SIDE, ca), 1'b0});
      step_letters.push_back(
        pfe_pkg::out_item_t'{square_cell((rb + 1) % pfe_pkg::SIDE, cb), 1'b0});
    end else begin
      step_letters.push_back(pfe_pkg::out_item_t'{square_cell(ra, cb), 1'b0});
      step_letters.push_back(pfe_pkg::out_item_t'{square_cell(rb, ca), 1'b0});
    end
  endfunction

  function automatic void predict_item(pfe_pkg::in_item_t item);
    pfe_pkg::letter_t l;
    step_letters.delete();
    l = plug_gap(item.plain_letter);
    if (!held_valid) begin
      held_letter = l;
      held_valid  = 1'b1;
    end else if (l == held_letter) begin
      // doubled letter: pad the held one, the new one stays held
      encipher(held_letter, pad_for(held_letter));
    end else begin
      encipher(held_letter, l);
      held_valid  = 1'b0;
      held_letter = '0;
    end
    if (item.end_of_message) begin
      if (held_valid) encipher(held_letter, pad_for(held_letter));
      step_letters[step_letters.size() - 1].final_letter = 1'b1;
      held_valid  = 1'b0;
      held_letter = '0;
    end
  endfunction

  // ---------------- drivers ----------------

  task automatic send_letter(pfe_pkg::in_item_t item, string known);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(item);
    if (known.len() != 0) begin
      for (int k = 0; k < known.len(); k++) begin
        cipher_due.push_back(pfe_pkg::out_item_t'{pfe_pkg::letter_t'(known[k] - 8'd65),
                                                  item.end_of_message && k == known.len() - 1});
      end
    end else begin
      foreach (step_letters[k]) cipher_due.push_back(step_letters[k]);
    end
  endtask

  // caller lowers cfg_valid_i once the batch is written
  task automatic write_reg(cfg_index_t idx, cfg_data_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pfe_pkg::CFG_ROW_0, pfe_pkg::CFG_ROW_1, pfe_pkg::CFG_ROW_2, pfe_pkg::CFG_ROW_3,
      pfe_pkg::CFG_ROW_4: square_rows[idx] = value;
      pfe_pkg::CFG_ABSENT:   absent_code   = value[pfe_pkg::LETTER_W-1:0];
      pfe_pkg::CFG_STAND_IN: stand_in_code = value[pfe_pkg::LETTER_W-1:0];
      default: ;
    endcase
  endtask

  // stop offering, let every owed letter arrive, then give the pipe time to empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (cipher_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic plan_row_t plain_row(byte ch, bit eom, string known);
    plan_row_t row;
    row.is_reg    = 1'b0;
    row.reg_index = '0;
    row.reg_value = '0;
    row.letter    = pfe_pkg::letter_t'(ch - 8'd65);
    row.eom       = eom;
    row.known     = known;
    return row;
  endfunction

  function automatic plan_row_t reg_row(cfg_index_t idx, cfg_data_t value);
    plan_row_t row;
    row.is_reg    = 1'b1;
    row.reg_index = idx;
    row.reg_value = value;
    row.letter    = '0;
    row.eom       = 1'b0;
    row.known     = "";
    return row;
  endfunction

  // ---------------- receiver ----------------

  initial begin : receiver_pattern
    int stretch, stall_pct;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_due) begin
        // long hold-off so the pair queue fills and the input stalls
        hold_off_due = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        stretch   = $urandom_range(4, 40);
        stall_pct = $urandom_range(0, 3) * 25;
        repeat (stretch) begin
          out_stall_i <= ($urandom_range(0, 99) < stall_pct);
          @(posedge clk_i);
        end
      end
    end
  end

  // ---------------- checker ----------------

  function automatic void note_failure(string what, pfe_pkg::out_item_t want,
                                       pfe_pkg::out_item_t got);
    if (failures < MAX_REPORTS) begin
      $display("mismatch at cycle %0d, %s: expected letter %0d last %0b, got letter %0d last %0b",
               cycles, what, want.cipher_letter, want.final_letter,
               got.cipher_letter, got.final_letter);
    end
    failures++;
  endfunction

  always @(posedge clk_i) begin : result_check
    pfe_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_due.size() == 0) begin
        note_failure("item with nothing owed", '0, out_item_o);
      end else begin
        want = cipher_due.pop_front();
        if (out_item_o.cipher_letter !== want.cipher_letter) begin
          note_failure("cipher letter", want, out_item_o);
        end else if (out_item_o.final_letter !== want.final_letter) begin
          note_failure("final flag", want, out_item_o);
        end
      end
    end
  end

  // ---------------- stimulus ----------------

  initial begin : main_flow
    plan_row_t         directed_plan [$];
    plan_row_t         row;
    pfe_pkg::in_item_t item;
    row_t              rows [5];
    pfe_pkg::letter_t  absent_pick, stand_pick, letter, prev;
    int                deck [26];
    int                j, t, sent, msg_len, pick;
    bit                in_cfg;

    for (int r = 0; r < pfe_pkg::SIDE; r++) square_rows[r] = pfe_pkg::SQUARE_RESET[r];
    absent_code   = pfe_pkg::ABSENT_RESET;
    stand_in_code = pfe_pkg::STAND_IN_RESET;
    held_letter   = '0;
    held_valid    = 1'b0;

    // default square ABCDE FGHIK LMNOP QRSTU VWXYZ, j folded into i
    directed_plan = '{
      plain_row("A", 1, "CV"),   plain_row("Z", 1, "VY"),
      plain_row("X", 1, "YW"),   plain_row("J", 1, "HY"),
      plain_row("A", 0, ""),     plain_row("A", 1, "CVCV"),
      plain_row("A", 0, ""),     plain_row("B", 1, "BC"),
      plain_row("A", 0, ""),     plain_row("F", 1, "FL"),
      plain_row("D", 0, ""),     plain_row("E", 1, "EA"),
      plain_row("V", 0, ""),     plain_row("A", 1, "AF"),
      plain_row("X", 0, ""),     plain_row("X", 1, "YWYW"),
      plain_row("H", 0, ""),     plain_row("I", 0, ""),
      plain_row("J", 0, ""),     plain_row("I", 1, ""),
      // x folded into i: the pad of a held i is i itself, both shift right in row
      reg_row(pfe_pkg::CFG_ABSENT, cfg_data_t'(pfe_pkg::FILL_MAIN)),
      plain_row("I", 1, "KK"),   plain_row("X", 1, ""),
      // row of all a: duplicates, and v through z drop out of the square
      reg_row(pfe_pkg::CFG_ROW_4, '0),
      plain_row("A", 0, ""),     plain_row("B", 1, ""),
      reg_row(CFG_PAST_END, '1),
      plain_row("Z", 1, "")
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_cfg = 1'b0;
    foreach (directed_plan[n]) begin
      row = directed_plan[n];
      if (row.is_reg) begin
        if (!in_cfg) begin
          settle();
          in_cfg = 1'b1;
        end
        write_reg(row.reg_index, row.reg_value);
      end else begin
        if (in_cfg) begin
          cfg_valid_i <= 1'b0;
          in_cfg = 1'b0;
        end
        item.plain_letter   = row.letter;
        item.end_of_message = row.eom;
        send_letter(item, row.known);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      // shuffled alphabet, the last card is the letter left out
      for (int k = 0; k < 26; k++) deck[k] = k;
      for (int k = 25; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = deck[k];
        deck[k] = deck[j];
        deck[j] = t;
      end
      if (phase == 1 || phase == 2) begin
        for (int k = 0; k < 25; k++) begin
          if (deck[k] == ((phase == 1) ? 0 : 25)) begin
            t = deck[k];
            deck[k] = deck[25];
            deck[25] = t;
          end
        end
      end
      for (int r = 0; r < pfe_pkg::SIDE; r++) begin
        for (int c = 0; c < pfe_pkg::SIDE; c++) begin
          rows[r][c*pfe_pkg::LETTER_W +: pfe_pkg::LETTER_W] = pfe_pkg::letter_t'(deck[5*r + c]);
        end
      end
      absent_pick = pfe_pkg::letter_t'(deck[25]);
      stand_pick  = pfe_pkg::letter_t'(deck[$urandom_range(0, 24)]);
      case (phase)
        1: stand_pick = 5'd25;
        2: stand_pick = 5'd0;
        3: begin
          // raw rows: codes past z, repeats and gaps
          for (int r = 0; r < pfe_pkg::SIDE; r++) rows[r] = row_t'($urandom());
          absent_pick = pfe_pkg::letter_t'($urandom_range(0, 25));
          stand_pick  = pfe_pkg::letter_t'($urandom_range(0, 25));
        end
        4: begin
          rows[0] = '0;
          rows[4] = '1;
        end
        5: stand_pick = absent_pick;  // the folded letter stays missing
        6: begin
          for (int r = 0; r < pfe_pkg::SIDE; r++) rows[r] = pfe_pkg::SQUARE_RESET[r];
          absent_pick = pfe_pkg::ABSENT_RESET;
          stand_pick  = pfe_pkg::STAND_IN_RESET;
        end
        default: ;
      endcase

      settle();
      for (int r = 0; r < pfe_pkg::SIDE; r++) begin
        write_reg(cfg_index_t'(pfe_pkg::CFG_ROW_0 + r), rows[r]);
      end
      write_reg(pfe_pkg::CFG_ABSENT, cfg_data_t'(absent_pick));
      write_reg(pfe_pkg::CFG_STAND_IN, cfg_data_t'(stand_pick));
      if (phase == 4) write_reg(CFG_PAST_END, '1);
      cfg_valid_i <= 1'b0;
      if (phase == 0) hold_off_due = 1'b1;

      // messages of random length, biased toward doubles, pads and the folded letter
      sent = 0;
      prev = '0;
      while (sent < PHASE_ITEMS) begin
        msg_len = $urandom_range(1, 12);
        for (int k = 0; k < msg_len && sent < PHASE_ITEMS; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 25) letter = prev;
          else if (pick < 35) letter = absent_code;
          else if (pick < 45) letter = $urandom_range(0, 1) ? pfe_pkg::FILL_MAIN : pfe_pkg::FILL_ALT;
          else letter = pfe_pkg::letter_t'($urandom_range(0, 25));
          item.plain_letter   = letter;
          item.end_of_message = (k == msg_len - 1) || (sent == PHASE_ITEMS - 1);
          send_letter(item, "");
          prev = letter;
          sent++;
        end
      end
    end

    settle();
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
